// ===== sv/gpp_pkg.sv =====
package gpp_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DECAY = 2'd1,
    OP_PLOT  = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_X_AXIS_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIT_THRESHOLD = 2'd2;

  localparam logic [7:0] DECAY_STEP_RESET    = 8'd24;
  localparam logic [7:0] LIT_THRESHOLD_RESET = 8'd96;

  localparam int COL_W  = 6;
  localparam int BITS_W = 24;
  localparam int AGE_W  = 8;

  localparam int STEM_SAMPLES = 6000;
  localparam int BRIGHT_FLOOR = 64;
  localparam int BRIGHT_CEIL  = 255;
  localparam int BRIGHT_GAIN  = 400;
  localparam int AMP_SHIFT    = 29;

  // +24 semitones in Q8.8, and half a row step of rounding
  localparam int PITCH_SPAN  = 6144;
  localparam int PITCH_ROUND = 12288;
  // y divisor 24576 = 3 * 2^13; the /3 goes by reciprocal 683 / 2^11
  localparam int Y_SHIFT  = 13;
  localparam int RECIP3   = 683;
  localparam int RECIP_SH = 11;

endpackage

// ===== sv/gpp_ram.sv =====
module gpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/grain_phosphor_plotter.sv =====
// Persistence field for a grain display: one 8-bit age per cell of a FIELD_WIDTH x
// FIELD_HEIGHT field, held in a single-port-write, registered-read RAM. One item
// is taken at a time; in_ready is high only between items. After reset the RAM is
// swept to zero, all FIELD_WIDTH*FIELD_HEIGHT cells (1536 by default), with in_ready
// low; configuration writes are taken throughout. A clear sweeps every cell to zero;
// a decay does one read-modify-write per cell through the RAM port; a plot does one
// read-modify-write per touched cell, up to MAX_STEM+1 cells; a scan reads every
// cell and is held while the output stalls. Scan gives one transfer per column;
// the last column sits in the output register while the next item is accepted.
module grain_phosphor_plotter
  import gpp_pkg::*;
#(
  parameter int FIELD_WIDTH  = 64,
  parameter int FIELD_HEIGHT = 24,
  parameter int MAX_STEM     = 6
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic signed [15:0]     pan_value,
  input  logic [14:0]            read_position,
  input  logic signed [15:0]     pitch_semitones,
  input  logic [15:0]            envelope_level,
  input  logic [15:0]            grain_gain,
  input  logic [23:0]            duration_samples,
  input  logic                   reverse_flag,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COL_W-1:0]       column_index,
  output logic [BITS_W-1:0]      column_bits,
  output logic                   last_column
);

  localparam int CELLS = FIELD_WIDTH * FIELD_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(FIELD_WIDTH);
  localparam int YW    = $clog2(FIELD_HEIGHT);
  localparam int SW    = $clog2(MAX_STEM + 2);

  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [XW-1:0] COL_LAST  = XW'(FIELD_WIDTH - 1);
  localparam logic [YW-1:0] ROW_LAST  = YW'(FIELD_HEIGHT - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DECAY,
    S_CALC,
    S_ADDR,
    S_PLOT,
    S_DRAIN,
    S_SCAN_RD,
    S_SCAN_WAIT,
    S_SCAN_PUT
  } state_t;

  typedef enum logic [1:0] {
    K_DECAY,
    K_RAISE,
    K_SCAN
  } kind_t;

  // a read issued last cycle, to be finished with the RAM data this cycle
  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [AW-1:0]    addr;
    logic [AGE_W-1:0] level;
    logic [YW-1:0]    row;
  } pend_t;

  state_t state;
  pend_t  pend;

  logic             x_axis_mode;
  logic [7:0]       decay_step;
  logic [7:0]       lit_threshold;

  logic [AW-1:0]    sweep;
  logic [XW-1:0]    scan_col;
  logic [YW-1:0]    scan_row;
  logic [BITS_W-1:0] col_acc;

  logic [XW-1:0]    plot_x;
  logic [YW-1:0]    plot_y;
  logic signed [24:0] y_num;
  logic [31:0]      prod;
  logic [SW-1:0]    stem;
  logic             rev;
  logic [AGE_W-1:0] bright;
  logic [AGE_W-1:0] level;
  logic [SW-1:0]    n_left;
  logic [AW-1:0]    rmw_addr;

  // accept-side arithmetic
  logic signed [16:0] pan_off;
  logic signed [24:0] pan_num;
  logic [21:0]        pos_num;
  logic [9:0]         x_pan;
  logic [9:0]         x_pos;
  logic [9:0]         x_sel;
  logic [XW-1:0]      x_in;
  logic signed [17:0] pitch_diff;
  logic signed [24:0] y_num_in;
  logic [31:0]        prod_in;
  logic [SW-1:0]      stem_in;

  // second stage
  logic [11:0]        y_div;
  logic [21:0]        y_recip;
  logic [10:0]        y_quot;
  logic [YW-1:0]      y_calc;
  logic [40:0]        amp_full;
  logic [11:0]        amp;
  logic [AGE_W-1:0]   bright_calc;

  // third stage
  logic [YW-1:0]      stem_lim;
  logic [SW-1:0]      stem_eff;
  logic [AW-1:0]      cell_addr;

  // RAM port
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AGE_W-1:0]   ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [AGE_W-1:0]   ram_rdata;

  logic               in_fire;
  logic               out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    pan_off  = 17'(pan_value) + 17'sd16384;
    pan_num  = 25'(pan_off) * 25'(FIELD_WIDTH - 1) + 25'sd16384;
    x_pan    = pan_num[24] ? 10'd0 : pan_num[24:15];
    pos_num  = 22'(read_position) * 22'(FIELD_WIDTH - 1) + 22'd8192;
    x_pos    = 10'(pos_num[21:14]);
    x_sel    = x_axis_mode ? x_pos : x_pan;
    x_in     = (x_sel > 10'(FIELD_WIDTH - 1)) ? COL_LAST : x_sel[XW-1:0];

    pitch_diff = 18'(PITCH_SPAN) - 18'(pitch_semitones);
    y_num_in   = 25'(pitch_diff) * 25'(2 * (FIELD_HEIGHT - 1)) + 25'(PITCH_ROUND);
    prod_in    = 32'(envelope_level) * 32'(grain_gain);
  end

  // stem height: how many multiples of the stem length the duration reaches
  always_comb begin
    stem_in = '0;
    for (int s = 1; s <= MAX_STEM; s++) begin
      if (duration_samples >= 24'(s * STEM_SAMPLES)) begin
        stem_in = stem_in + 1'b1;
      end
    end
  end

  always_comb begin
    y_div    = y_num[24] ? 12'd0 : y_num[24:Y_SHIFT];
    y_recip  = 22'(y_div) * 22'(RECIP3);
    y_quot   = y_recip[21:RECIP_SH];
    y_calc   = (y_quot > 11'(FIELD_HEIGHT - 1)) ? ROW_LAST : y_quot[YW-1:0];

    amp_full = 41'(prod) * 41'(BRIGHT_GAIN);
    amp      = amp_full[40:AMP_SHIFT];
    bright_calc = (amp > 12'(BRIGHT_CEIL - BRIGHT_FLOOR)) ? AGE_W'(BRIGHT_CEIL)
                : AGE_W'(BRIGHT_FLOOR) + amp[AGE_W-1:0];
  end

  // the stem stops at the field edge
  always_comb begin
    stem_lim  = rev ? plot_y : ROW_LAST - plot_y;
    stem_eff  = (8'(stem_lim) < 8'(stem)) ? SW'(stem_lim) : stem;
    cell_addr = AW'(plot_x) * AW'(FIELD_HEIGHT) + AW'(plot_y);
  end

  always_comb begin
    ram_raddr = (state == S_PLOT) ? rmw_addr : sweep;
    ram_we    = (state == S_CLEAR) || (pend.valid && pend.kind != K_SCAN);
    ram_waddr = (state == S_CLEAR) ? sweep : pend.addr;
    case (pend.kind)
      K_DECAY: ram_wdata = (ram_rdata > decay_step) ? ram_rdata - decay_step : '0;
      K_RAISE: ram_wdata = (ram_rdata < pend.level) ? pend.level : ram_rdata;
      default: ram_wdata = '0;
    endcase
    if (state == S_CLEAR) begin
      ram_wdata = '0;
    end
  end

  gpp_ram #(
    .WIDTH(AGE_W),
    .DEPTH(CELLS)
  ) u_age_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sweep         <= '0;
      pend.valid    <= 1'b0;
      out_valid     <= 1'b0;
      x_axis_mode   <= 1'b0;
      decay_step    <= DECAY_STEP_RESET;
      lit_threshold <= LIT_THRESHOLD_RESET;
    end else begin
      // a read is issued in every cycle of the decay sweep, plot and column-read states
      pend.valid <= (state == S_DECAY) || (state == S_PLOT) || (state == S_SCAN_RD);

      if (cfg_write) begin
        case (cfg_index)
          REG_X_AXIS_MODE:   x_axis_mode   <= cfg_data[0];
          REG_DECAY_STEP:    decay_step    <= cfg_data;
          REG_LIT_THRESHOLD: lit_threshold <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != S_SCAN_PUT) begin
        out_valid <= 1'b0;
      end

      if (pend.valid && pend.kind == K_SCAN && ram_rdata > lit_threshold) begin
        col_acc <= col_acc | (BITS_W'(1) << pend.row);
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            sweep    <= '0;
            scan_col <= '0;
            scan_row <= '0;
            col_acc  <= '0;
            plot_x   <= x_in;
            y_num    <= y_num_in;
            prod     <= prod_in;
            stem     <= stem_in;
            rev      <= reverse_flag;
            case (op_t'(operation))
              OP_CLEAR: state <= S_CLEAR;
              OP_DECAY: state <= S_DECAY;
              OP_PLOT:  state <= S_CALC;
              OP_SCAN:  state <= S_SCAN_RD;
              default:  state <= S_IDLE;
            endcase
          end
        end

        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == CELL_LAST) begin
            state <= S_IDLE;
          end
        end

        S_DECAY: begin
          pend.kind  <= K_DECAY;
          pend.addr  <= sweep;
          sweep      <= sweep + 1'b1;
          if (sweep == CELL_LAST) begin
            state <= S_DRAIN;
          end
        end

        S_CALC: begin
          plot_y <= y_calc;
          bright <= bright_calc;
          state  <= S_ADDR;
        end

        S_ADDR: begin
          rmw_addr <= cell_addr;
          n_left   <= stem_eff;
          level    <= bright;
          state    <= S_PLOT;
        end

        S_PLOT: begin
          pend.kind  <= K_RAISE;
          pend.addr  <= rmw_addr;
          pend.level <= level;
          level      <= bright >> 1;
          rmw_addr   <= rev ? rmw_addr - 1'b1 : rmw_addr + 1'b1;
          n_left     <= n_left - 1'b1;
          if (n_left == '0) begin
            state <= S_DRAIN;
          end
        end

        // last write-back lands here
        S_DRAIN: begin
          state <= S_IDLE;
        end

        S_SCAN_RD: begin
          pend.kind  <= K_SCAN;
          pend.addr  <= sweep;
          pend.row   <= scan_row;
          sweep      <= sweep + 1'b1;
          scan_row   <= scan_row + 1'b1;
          if (scan_row == ROW_LAST) begin
            state <= S_SCAN_WAIT;
          end
        end

        S_SCAN_WAIT: begin
          state <= S_SCAN_PUT;
        end

        S_SCAN_PUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            column_index <= COL_W'(scan_col);
            column_bits  <= col_acc;
            last_column  <= (scan_col == COL_LAST);
            col_acc      <= '0;
            scan_row     <= '0;
            scan_col     <= scan_col + 1'b1;
            state        <= (scan_col == COL_LAST) ? S_IDLE : S_SCAN_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // no write-back may still be outstanding when a new item can enter
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !pend.valid)
    else $error("write-back outstanding while idle");

  // the clearing sweep owns the write port alone
  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !pend.valid)
    else $error("write-back during clearing sweep");

  // every write-back or scan sample belongs to the address read the cycle before
  assert property (@(posedge clk) disable iff (rst) pend.valid |-> pend.addr == $past(ram_raddr))
    else $error("finished access does not match issued read");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_column == (column_index == COL_W'(FIELD_WIDTH - 1))))
    else $error("last column flag out of step with column index");

endmodule
